[rtl/bccf_pkg.sv]
`default_nettype none

package bccf_pkg;

  // Breakpoint counts of the capacity table.
  localparam int unsigned VOLT_POINTS = 8;
  localparam int unsigned TEMP_POINTS = 8;

  // Field widths.
  localparam int unsigned V_W      = 13;
  localparam int unsigned T_W      = 8;
  localparam int unsigned CAP_W    = 14;
  localparam int unsigned Q_FRAC   = 14;
  localparam int unsigned Q_W      = Q_FRAC + 1;

  // Segment widths are bounded by the breakpoint tables below.
  localparam int unsigned DV_SPAN_W = 8;
  localparam int unsigned DT_SPAN_W = 4;
  localparam int unsigned DV_OFF_W  = V_W + 1;
  localparam int unsigned DT_OFF_W  = T_W + 1;

  localparam int unsigned VIDX_W = $clog2(VOLT_POINTS);
  localparam int unsigned TIDX_W = $clog2(TEMP_POINTS);

  localparam int unsigned FIFO_DEPTH = 4;

  // Full scale of 120 Ah in units of 0.01 Ah.
  localparam logic [CAP_W-1:0] FULL_SCALE_CAH = 14'd12000;

  localparam logic [V_W-1:0] VOLT_BP [VOLT_POINTS] = '{
    13'd3389, 13'd3399, 13'd3405, 13'd3422, 13'd3440, 13'd3475, 13'd3630, 13'd3650
  };

  localparam logic signed [T_W-1:0] TEMP_BP [TEMP_POINTS] = '{
    8'sd0, 8'sd5, 8'sd10, 8'sd15, 8'sd20, 8'sd25, 8'sd35, 8'sd45
  };

  // Rows follow the temperature breakpoints, columns the voltage breakpoints.
  localparam logic [CAP_W-1:0] CAP_TAB [TEMP_POINTS][VOLT_POINTS] = '{
    '{14'd6989,  14'd7429,  14'd7718,  14'd9350,  14'd10541, 14'd11360, 14'd11878, 14'd11900},
    '{14'd7596,  14'd8030,  14'd8692,  14'd10437, 14'd11178, 14'd11675, 14'd12000, 14'd12000},
    '{14'd8179,  14'd9878,  14'd10557, 14'd11446, 14'd11786, 14'd12000, 14'd12000, 14'd12000},
    '{14'd9932,  14'd11100, 14'd11360, 14'd11812, 14'd12000, 14'd12000, 14'd12000, 14'd12000},
    '{14'd10784, 14'd11527, 14'd11728, 14'd12000, 14'd12000, 14'd12000, 14'd12000, 14'd12000},
    '{14'd11458, 14'd11884, 14'd12000, 14'd12000, 14'd12000, 14'd12000, 14'd12000, 14'd12000},
    '{14'd11919, 14'd12000, 14'd12000, 14'd12000, 14'd12000, 14'd12000, 14'd12000, 14'd12000},
    '{14'd12000, 14'd12000, 14'd12000, 14'd12000, 14'd12000, 14'd12000, 14'd12000, 14'd12000}
  };

  // A classified sample: offsets into the chosen segments, their spans and
  // the four corner capacities.
  typedef struct packed {
    logic [DV_OFF_W-1:0]  dv_off;
    logic [DV_SPAN_W-1:0] dv_span;
    logic [DT_OFF_W-1:0]  dt_off;
    logic [DT_SPAN_W-1:0] dt_span;
    logic [CAP_W-1:0]     a11;
    logic [CAP_W-1:0]     a12;
    logic [CAP_W-1:0]     a21;
    logic [CAP_W-1:0]     a22;
  } bccf_item_t;

endpackage

`default_nettype wire

[rtl/bccf_front.sv]
`default_nettype none

module bccf_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [12:0]            cell_voltage_mv_i,
  input  logic [7:0]             temperature_c_i,
  output logic                   push_valid_o,
  input  logic                   push_ready_i,
  output bccf_pkg::bccf_item_t   push_item_o
);
  import bccf_pkg::*;

  logic              valid_q;
  logic [V_W-1:0]    v_q;
  logic [T_W-1:0]    t_q;
  logic [VIDX_W-1:0] vi_q, vi_d;
  logic [TIDX_W-1:0] tj_q, tj_d;

  logic [VIDX_W-1:0] vlo_idx;
  logic [TIDX_W-1:0] tlo_idx;
  logic [V_W-1:0]    vlo, vhi;
  logic [T_W-1:0]    tlo, thi;
  logic [V_W-1:0]    vspan;
  logic [T_W-1:0]    tspan;

  assign in_ready_o   = !valid_q || push_ready_i;
  assign push_valid_o = valid_q;

  // The upper breakpoint of the segment is one more than the number of inner
  // breakpoints that lie strictly below the sample; this also covers both
  // extrapolating ends.
  always_comb begin
    logic [VIDX_W-1:0] vcnt;
    logic [TIDX_W-1:0] tcnt;
    vcnt = '0;
    tcnt = '0;
    for (int k = 1; k < VOLT_POINTS - 1; k++) begin
      vcnt = vcnt + VIDX_W'(cell_voltage_mv_i > VOLT_BP[k]);
    end
    for (int k = 1; k < TEMP_POINTS - 1; k++) begin
      tcnt = tcnt + TIDX_W'($signed(temperature_c_i) > TEMP_BP[k]);
    end
    vi_d = vcnt + VIDX_W'(1);
    tj_d = tcnt + TIDX_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      v_q  <= cell_voltage_mv_i;
      t_q  <= temperature_c_i;
      vi_q <= vi_d;
      tj_q <= tj_d;
    end
  end

  always_comb begin
    vlo_idx = vi_q - VIDX_W'(1);
    tlo_idx = tj_q - TIDX_W'(1);
    vlo     = VOLT_BP[vlo_idx];
    vhi     = VOLT_BP[vi_q];
    tlo     = TEMP_BP[tlo_idx];
    thi     = TEMP_BP[tj_q];
    vspan   = vhi - vlo;
    tspan   = thi - tlo;

    push_item_o.dv_off  = {1'b0, v_q} - {1'b0, vlo};
    push_item_o.dv_span = vspan[DV_SPAN_W-1:0];
    push_item_o.dt_off  = {t_q[T_W-1], t_q} - {tlo[T_W-1], tlo};
    push_item_o.dt_span = tspan[DT_SPAN_W-1:0];
    push_item_o.a11     = CAP_TAB[tlo_idx][vlo_idx];
    push_item_o.a12     = CAP_TAB[tlo_idx][vi_q];
    push_item_o.a21     = CAP_TAB[tj_q][vlo_idx];
    push_item_o.a22     = CAP_TAB[tj_q][vi_q];
  end

endmodule

`default_nettype wire

[rtl/bccf_fifo.sv]
`default_nettype none

module bccf_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  bccf_pkg::bccf_item_t push_item_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output bccf_pkg::bccf_item_t pop_item_o
);
  import bccf_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  bccf_item_t       entry_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

[rtl/bccf_back.sv]
`default_nettype none

module bccf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  bccf_pkg::bccf_item_t pop_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [14:0]          capacity_factor_q14_o,
  output logic                 saturated_o
);
  import bccf_pkg::*;

  localparam int unsigned DIFF_W = CAP_W + 1;
  localparam int unsigned P1_W   = CAP_W + DV_SPAN_W;
  localparam int unsigned P2_W   = DV_OFF_W + DIFF_W;
  localparam int unsigned X_W    = P2_W + 1;
  localparam int unsigned XD_W   = X_W + 1;
  localparam int unsigned M1_W   = X_W + DT_SPAN_W + 1;
  localparam int unsigned M2_W   = DT_OFF_W + XD_W;
  localparam int unsigned NUM_W  = M2_W + 1;
  localparam int unsigned DD_W   = DV_SPAN_W + DT_SPAN_W;
  localparam int unsigned DEN_W  = DD_W + CAP_W;
  // Six arithmetic stages, the divide stages and the output register.
  localparam int unsigned NSTAGE = Q_FRAC + 8;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
    logic             big;
    logic             neg;
  } div_t;

  logic              en;
  logic [NSTAGE-1:0] vld_q;

  // Stage 1: corner products.
  logic        [P1_W-1:0]      p1_q, p1_d, p3_q, p3_d;
  logic signed [P2_W-1:0]      p2_q, p2_d, p4_q, p4_d;
  logic        [DD_W-1:0]      dd_q, dd_d;
  logic signed [DT_OFF_W-1:0]  dt1_q;
  logic        [DT_SPAN_W-1:0] dts1_q;
  // Stage 2: interpolation along voltage.
  logic signed [X_W-1:0]       x1_q, x1_d, x2_q, x2_d;
  logic        [DEN_W-1:0]     den2_q, den2_d;
  logic signed [DT_OFF_W-1:0]  dt2_q;
  logic        [DT_SPAN_W-1:0] dts2_q;
  // Stages 3 to 5: interpolation along temperature.
  logic signed [XD_W-1:0]      xd_q, xd_d;
  logic signed [M1_W-1:0]      m1_3_q, m1_3_d, m1_4_q;
  logic signed [DT_OFF_W-1:0]  dt3_q;
  logic signed [M2_W-1:0]      m2_q, m2_d;
  logic signed [NUM_W-1:0]     num_q, num_d;
  logic        [DEN_W-1:0]     den3_q, den4_q, den5_q, den6_q;
  // Stage 6: magnitude and sign.
  logic        [NUM_W-1:0]     mag_q, mag_d;
  logic                        neg6_q;

  div_t div_q [Q_FRAC+1];
  div_t div_d [Q_FRAC+1];

  logic [Q_W-1:0] factor_q, factor_d;
  logic           sat_q, sat_d;

  assign out_valid_o           = vld_q[NSTAGE-1];
  assign en                    = !out_valid_o || out_ready_i;
  assign pop_ready_o           = en;
  assign capacity_factor_q14_o = factor_q;
  assign saturated_o           = sat_q;

  always_comb begin
    logic signed [DIFF_W-1:0] d12, d34;
    logic signed [DV_OFF_W-1:0] dvo;
    d12  = $signed({1'b0, pop_item_i.a12}) - $signed({1'b0, pop_item_i.a11});
    d34  = $signed({1'b0, pop_item_i.a22}) - $signed({1'b0, pop_item_i.a21});
    dvo  = $signed(pop_item_i.dv_off);
    p1_d = pop_item_i.a11 * pop_item_i.dv_span;
    p3_d = pop_item_i.a21 * pop_item_i.dv_span;
    p2_d = dvo * d12;
    p4_d = dvo * d34;
    dd_d = pop_item_i.dv_span * pop_item_i.dt_span;
  end

  always_comb begin
    x1_d   = $signed({1'b0, p1_q}) + p2_q;
    x2_d   = $signed({1'b0, p3_q}) + p4_q;
    den2_d = dd_q * FULL_SCALE_CAH;
  end

  always_comb begin
    xd_d   = x2_q - x1_q;
    m1_3_d = x1_q * $signed({1'b0, dts2_q});
    m2_d   = dt3_q * xd_q;
    num_d  = m1_4_q + m2_q;
    mag_d  = num_q[NUM_W-1] ? $unsigned(-num_q) : $unsigned(num_q);
  end

  // First quotient bit, plus the check that the quotient cannot fit, then one
  // restoring step per stage; the remainder stays below den unless it cannot fit.
  always_comb begin
    logic [NUM_W-1:0] sub0;
    logic             ge0;
    ge0            = mag_q >= NUM_W'(den6_q);
    sub0           = mag_q - NUM_W'(den6_q);
    div_d[0].big   = mag_q >= NUM_W'({den6_q, 1'b0});
    div_d[0].neg   = neg6_q;
    div_d[0].den   = den6_q;
    div_d[0].quo   = Q_W'(ge0);
    div_d[0].rem   = ge0 ? sub0[DEN_W-1:0] : mag_q[DEN_W-1:0];
    for (int s = 1; s <= Q_FRAC; s++) begin
      logic [DEN_W:0] rem2;
      logic [DEN_W:0] diff;
      logic           b;
      rem2         = {div_q[s-1].rem, 1'b0};
      diff         = rem2 - {1'b0, div_q[s-1].den};
      b            = rem2 >= {1'b0, div_q[s-1].den};
      div_d[s].rem = b ? diff[DEN_W-1:0] : rem2[DEN_W-1:0];
      div_d[s].den = div_q[s-1].den;
      div_d[s].quo = {div_q[s-1].quo[Q_W-2:0], b};
      div_d[s].big = div_q[s-1].big;
      div_d[s].neg = div_q[s-1].neg;
    end
  end

  always_comb begin
    if (div_q[Q_FRAC].neg) begin
      factor_d = '0;
      sat_d    = div_q[Q_FRAC].big || (div_q[Q_FRAC].quo != '0);
    end else if (div_q[Q_FRAC].big) begin
      factor_d = '1;
      sat_d    = 1'b1;
    end else begin
      factor_d = div_q[Q_FRAC].quo;
      sat_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTAGE-2:0], pop_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q     <= p1_d;
      p2_q     <= p2_d;
      p3_q     <= p3_d;
      p4_q     <= p4_d;
      dd_q     <= dd_d;
      dt1_q    <= $signed(pop_item_i.dt_off);
      dts1_q   <= pop_item_i.dt_span;

      x1_q     <= x1_d;
      x2_q     <= x2_d;
      den2_q   <= den2_d;
      dt2_q    <= dt1_q;
      dts2_q   <= dts1_q;

      xd_q     <= xd_d;
      m1_3_q   <= m1_3_d;
      dt3_q    <= dt2_q;
      den3_q   <= den2_q;

      m2_q     <= m2_d;
      m1_4_q   <= m1_3_q;
      den4_q   <= den3_q;

      num_q    <= num_d;
      den5_q   <= den4_q;

      mag_q    <= mag_d;
      neg6_q   <= num_q[NUM_W-1];
      den6_q   <= den5_q;

      for (int s = 0; s <= Q_FRAC; s++) begin
        div_q[s] <= div_d[s];
      end

      factor_q <= factor_d;
      sat_q    <= sat_d;
    end
  end

endmodule

`default_nettype wire

[rtl/bilinear_charge_capacity_factor.sv]
`default_nettype none

// Channel   Handshake               Payload
// in        in_valid_i/in_ready_o   cell_voltage_mv_i[12:0], temperature_c_i[7:0] (signed)
// out       out_valid_o/out_ready_i capacity_factor_q14_o[14:0], saturated_o
//
// One sample is accepted per cycle while input ready is high. Each result
// passes the front register, the queue and the back pipeline, whose fifteen
// one-bit restoring divide stages scale the interpolated capacity.
// Reset clears all valid flags and the queue; no table needs filling.
// A stalled output holds the back pipeline while the front keeps filling a
// four-entry queue, and input ready drops only once that queue is full.
module bilinear_charge_capacity_factor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [12:0] cell_voltage_mv_i,
  input  logic [7:0]  temperature_c_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [14:0] capacity_factor_q14_o,
  output logic        saturated_o
);
  import bccf_pkg::*;

  logic       push_valid, push_ready;
  logic       pop_valid, pop_ready;
  bccf_item_t push_item, pop_item;

  bccf_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .cell_voltage_mv_i (cell_voltage_mv_i),
    .temperature_c_i   (temperature_c_i),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .push_item_o       (push_item)
  );

  bccf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  bccf_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .pop_valid_i           (pop_valid),
    .pop_ready_o           (pop_ready),
    .pop_item_i            (pop_item),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .capacity_factor_q14_o (capacity_factor_q14_o),
    .saturated_o           (saturated_o)
  );

endmodule

`default_nettype wire

[dv/bilinear_charge_capacity_factor_tb.sv]
`default_nettype none

module bilinear_charge_capacity_factor_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 1200;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int REPORT_LIMIT  = 10;
  localparam int LONG_HOLD_LEN = 300;

  localparam int KNEE_COUNT = 8;
  localparam int FULL_CAH   = 12000;
  localparam int Q14_UNIT   = 16384;
  localparam int FACTOR_TOP = 32767;

  localparam int VOLT_KNEE_MV [KNEE_COUNT] = '{3389, 3399, 3405, 3422, 3440, 3475, 3630, 3650};
  localparam int TEMP_KNEE_C  [KNEE_COUNT] = '{0, 5, 10, 15, 20, 25, 35, 45};

  // End-of-charge capacity in 0.01 Ah; rows by temperature, columns by voltage.
  localparam int CHARGE_CAH [KNEE_COUNT][KNEE_COUNT] = '{
    '{ 6989,  7429,  7718,  9350, 10541, 11360, 11878, 11900},
    '{ 7596,  8030,  8692, 10437, 11178, 11675, 12000, 12000},
    '{ 8179,  9878, 10557, 11446, 11786, 12000, 12000, 12000},
    '{ 9932, 11100, 11360, 11812, 12000, 12000, 12000, 12000},
    '{10784, 11527, 11728, 12000, 12000, 12000, 12000, 12000},
    '{11458, 11884, 12000, 12000, 12000, 12000, 12000, 12000},
    '{11919, 12000, 12000, 12000, 12000, 12000, 12000, 12000},
    '{12000, 12000, 12000, 12000, 12000, 12000, 12000, 12000}
  };

  typedef struct {
    logic [14:0] factor;
    logic        saturated;
  } capacity_factor_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [12:0] cell_voltage_mv_i;
  logic [7:0]  temperature_c_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [14:0] capacity_factor_q14_o;
  logic        saturated_o;

  int unsigned cycle_count;

  class capacity_scoreboard;
    capacity_factor_t factor_q[$];
    int unsigned      mismatches;

    // Upper knee index of the segment used; the end segments extend outwards.
    static function int upper_knee(input longint x, input int knees[KNEE_COUNT]);
      if (x <= knees[0]) return 1;
      for (int k = 1; k < KNEE_COUNT; k++) begin
        if (x <= knees[k]) return k;
      end
      return KNEE_COUNT - 1;
    endfunction

    static function capacity_factor_t interpolate_factor(input logic [12:0] volt_mv,
                                                         input logic [7:0]  temp_raw);
      capacity_factor_t res;
      longint v, t, dv, span_v, dt, span_t, x1, x2, num, den, f;
      int i, j;
      v = longint'(volt_mv);
      t = longint'($signed(temp_raw));
      i = upper_knee(v, VOLT_KNEE_MV);
      j = upper_knee(t, TEMP_KNEE_C);
      dv = v - VOLT_KNEE_MV[i-1];
      span_v = VOLT_KNEE_MV[i] - VOLT_KNEE_MV[i-1];
      dt = t - TEMP_KNEE_C[j-1];
      span_t = TEMP_KNEE_C[j] - TEMP_KNEE_C[j-1];
      x1 = CHARGE_CAH[j-1][i-1] * span_v + dv * (CHARGE_CAH[j-1][i] - CHARGE_CAH[j-1][i-1]);
      x2 = CHARGE_CAH[j][i-1] * span_v + dv * (CHARGE_CAH[j][i] - CHARGE_CAH[j][i-1]);
      num = x1 * span_t + dt * (x2 - x1);
      den = longint'(FULL_CAH) * span_v * span_t;
      // Division of signed integers truncates toward zero, as required.
      f = (num * Q14_UNIT) / den;
      res.saturated = 1'b0;
      if (f < 0) begin
        f = 0;
        res.saturated = 1'b1;
      end else if (f > FACTOR_TOP) begin
        f = FACTOR_TOP;
        res.saturated = 1'b1;
      end
      res.factor = f[14:0];
      return res;
    endfunction

    function void note_sample(input logic [12:0] volt_mv, input logic [7:0] temp_raw);
      factor_q.push_back(interpolate_factor(volt_mv, temp_raw));
    endfunction

    function void check_factor(input logic [14:0] factor, input logic saturated);
      capacity_factor_t want;
      if (factor_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with nothing outstanding: factor=%0d saturated=%0b",
                   $realtime, factor, saturated);
        return;
      end
      want = factor_q.pop_front();
      if (factor !== want.factor || saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: factor expected %0d sat %0b, got %0d sat %0b", $realtime,
                   want.factor, want.saturated, factor, saturated);
      end
    endfunction

    function int pending();
      return factor_q.size();
    endfunction
  endclass

  capacity_scoreboard factor_sb;

  bilinear_charge_capacity_factor u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .cell_voltage_mv_i     (cell_voltage_mv_i),
    .temperature_c_i       (temperature_c_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .capacity_factor_q14_o (capacity_factor_q14_o),
    .saturated_o           (saturated_o)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offers one sample and returns at the edge where the transaction completes.
  task automatic offer_sample(input logic [12:0] volt_mv, input logic [7:0] temp_raw);
    in_valid_i        <= 1'b1;
    cell_voltage_mv_i <= volt_mv;
    temperature_c_i   <= temp_raw;
    do @(posedge clk_i); while (!in_ready_o);
    factor_sb.note_sample(volt_mv, temp_raw);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles == 0) return;
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Receiver: a stall pattern chosen at random from four modes, plus a long
  // hold-off now and then so that the queue fills and input ready drops.
  initial begin
    int unsigned rx_cycle;
    int unsigned rx_mode;
    int unsigned hold_left;
    rx_cycle  = 0;
    rx_mode   = 0;
    hold_left = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        factor_sb.check_factor(capacity_factor_q14_o, saturated_o);
      rx_cycle++;
      if (rx_cycle % 2000 == 600) hold_left = LONG_HOLD_LEN;
      if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= (rx_cycle % 7) >= 2;
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    logic [12:0] volt_mv;
    logic [7:0]  temp_raw;
    factor_sb = new();
    cycle_count       = 0;
    rst_ni            = 1'b0;
    in_valid_i        = 1'b0;
    cell_voltage_mv_i = '0;
    temperature_c_i   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: exact knees, interior points, both extrapolations and clamping.
    offer_sample(13'd3389, 8'sd0);
    offer_sample(13'd3650, 8'sd45);
    offer_sample(13'd3399, 8'sd5);
    offer_sample(13'd3500, 8'sd22);
    offer_sample(13'd3630, 8'sd35);
    offer_sample(13'd3410, 8'sd12);
    offer_sample(13'd3440, 8'sd20);
    offer_sample(13'd3388, 8'sd0);
    offer_sample(13'd3651, 8'sd46);
    offer_sample(13'd3389, -8'sd1);
    offer_sample(13'd0, 8'sd0);
    offer_sample(13'd0, -8'sd128);
    offer_sample(13'd0, 8'sd127);
    offer_sample(13'd8191, 8'sd127);
    offer_sample(13'd8191, -8'sd128);
    offer_sample(13'd5000, 8'sd25);
    offer_sample(13'd4096, -8'sd1);
    offer_sample(13'd3300, 8'sd10);
    offer_sample(13'd3700, -8'sd20);
    offer_sample(13'd3475, 8'sd15);
    offer_sample(13'd3422, 8'sd60);
    offer_sample(13'd3405, 8'sd127);
    offer_sample(13'd2731, 8'sd85);
    pause_sender(5);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        case ($urandom_range(0, 9))
          0, 1:    volt_mv = 13'($urandom_range(0, 5000));
          2:       volt_mv = 13'($urandom_range(0, 8191));
          default: volt_mv = 13'($urandom_range(3370, 3670));
        endcase
        if ($urandom_range(0, 9) < 7) temp_raw = 8'($urandom_range(0, 55) - 5);
        else                          temp_raw = 8'($urandom_range(0, 255));
        offer_sample(volt_mv, temp_raw);
        sent++;
      end
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
    in_valid_i <= 1'b0;

    while (factor_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (factor_sb.mismatches == 0 && factor_sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/bccf_pkg.sv
rtl/bccf_front.sv
rtl/bccf_fifo.sv
rtl/bccf_back.sv
rtl/bilinear_charge_capacity_factor.sv
dv/bilinear_charge_capacity_factor_tb.sv
